[hdl/spq_pkg.sv]
// shared types and constants for the stable priority queue
package spq_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned DataW        = 32;
  localparam int unsigned PrioW        = 8;
  localparam int unsigned CountOutW    = 5;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    ACT_ENQUEUE = 1'b0,
    ACT_DEQUEUE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    FSM_IDLE  = 2'd0,
    FSM_SCAN  = 2'd1,
    FSM_APPLY = 2'd2
  } fsm_state_e;

  // one request transaction
  typedef struct packed {
    logic             action;
    logic [DataW-1:0] item_data;
    logic [PrioW-1:0] item_priority;
  } spq_cmd_t;

  // one result transaction
  typedef struct packed {
    logic [DataW-1:0]     out_data;
    logic [PrioW-1:0]     out_priority;
    logic                 out_valid;
    logic [DataW-1:0]     head_data;
    logic [PrioW-1:0]     head_priority;
    logic                 is_empty;
    logic [CountOutW-1:0] entry_count;
    logic [1:0]           status;
  } spq_result_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
  } spq_ctrl_t;

endpackage

[hdl/spq_ctrl.sv]
// controller state machine: sequences load, scan and apply per transaction
module spq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output spq_pkg::spq_ctrl_t ctrl_o
);
  import spq_pkg::*;

  fsm_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE:  if (start) state_d = FSM_SCAN;
      FSM_SCAN:  state_d = FSM_APPLY;
      FSM_APPLY: state_d = FSM_IDLE;
      default:   state_d = FSM_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o = '0;
    busy   = 1'b1;
    case (state_q)
      FSM_IDLE: begin
        busy        = 1'b0;
        ctrl_o.load = start;
      end
      FSM_SCAN:  ctrl_o.scan  = 1'b1;
      FSM_APPLY: ctrl_o.apply = 1'b1;
      default:   busy = 1'b0;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/spq_datapath.sv]
// datapath: row of entry cells, parallel compare, insert and shift logic
module spq_datapath #(
  parameter int unsigned DEPTH = spq_pkg::DepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  spq_pkg::spq_ctrl_t   ctrl_i,
  input  spq_pkg::spq_cmd_t    cmd_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_data_i,
  output spq_pkg::spq_result_t result_o,
  output logic                 result_valid_o
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DataW-1:0] data_q [DEPTH];
  logic [DataW-1:0] data_d [DEPTH];
  logic [PrioW-1:0] prio_q [DEPTH];
  logic [PrioW-1:0] prio_d [DEPTH];
  logic [CW-1:0]    count_q, count_d;
  logic             mode_q;
  spq_cmd_t         cmd_q;
  logic [DEPTH-1:0] lt_q, lt_d;
  logic [DEPTH-1:0] at_count, cand, first_oh, after;
  spq_result_t      result_q, result_d;
  logic             result_valid_q;
  logic             full, empty, do_ins, do_del;

  assign full   = (count_q == CW'(DEPTH));
  assign empty  = (count_q == '0);
  assign do_ins = (cmd_q.action == ACT_ENQUEUE) && !full;
  assign do_del = (cmd_q.action == ACT_DEQUEUE) && !empty;

  // per cell compare and insert position flags
  for (genvar g = 0; g < DEPTH; g++) begin : g_flag
    assign lt_d[g]     = mode_q && (CW'(g) < count_q)
                         && (prio_q[g] < cmd_q.item_priority);
    assign at_count[g] = (count_q == CW'(g));
  end

  // lowest candidate wins: first lower-priority entry, else the back
  assign cand     = lt_q | at_count;
  assign first_oh = cand & (~cand + DEPTH'(1));
  assign after    = ~(first_oh - DEPTH'(1));

  // next value of each cell
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DataW-1:0] lower_data, upper_data;
    logic [PrioW-1:0] lower_prio, upper_prio;
    if (g == 0) begin : g_lo
      assign lower_data = data_q[g];
      assign lower_prio = prio_q[g];
    end else begin : g_lo
      assign lower_data = data_q[g-1];
      assign lower_prio = prio_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_hi
      assign upper_data = data_q[g];
      assign upper_prio = prio_q[g];
    end else begin : g_hi
      assign upper_data = data_q[g+1];
      assign upper_prio = prio_q[g+1];
    end
    always_comb begin
      data_d[g] = data_q[g];
      prio_d[g] = prio_q[g];
      if (do_ins && first_oh[g]) begin
        data_d[g] = cmd_q.item_data;
        prio_d[g] = cmd_q.item_priority;
      end else if (do_ins && after[g]) begin
        data_d[g] = lower_data;
        prio_d[g] = lower_prio;
      end else if (do_del) begin
        data_d[g] = upper_data;
        prio_d[g] = upper_prio;
      end
    end
  end

  // count and result fields
  always_comb begin
    count_d  = count_q;
    result_d = '0;
    if (do_ins) begin
      count_d = count_q + CW'(1);
    end else if (do_del) begin
      count_d                = count_q - CW'(1);
      result_d.out_data      = data_q[0];
      result_d.out_priority  = prio_q[0];
      result_d.out_valid     = 1'b1;
    end
    if (cmd_q.action == ACT_ENQUEUE && full) begin
      result_d.status = ST_FULL;
    end else if (cmd_q.action == ACT_DEQUEUE && empty) begin
      result_d.status = ST_EMPTY;
    end else begin
      result_d.status = ST_OK;
    end
    result_d.is_empty    = (count_d == '0);
    result_d.entry_count = CountOutW'(count_d);
    if (count_d != '0) begin
      result_d.head_data     = data_d[0];
      result_d.head_priority = prio_d[0];
    end
  end

  // payload registers: request, compare flags, cells, result
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) cmd_q <= cmd_i;
    if (ctrl_i.scan) lt_q <= lt_d;
    if (ctrl_i.apply) begin
      for (int i = 0; i < DEPTH; i++) begin
        data_q[i] <= data_d[i];
        prio_q[i] <= prio_d[i];
      end
      result_q <= result_d;
    end
  end

  // control registers: fill count, mode, result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      mode_q         <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.apply) count_q <= count_d;
      if (cfg_we_i) mode_q <= cfg_data_i;
      result_valid_q <= ctrl_i.apply;
    end
  end

  assign result_o       = result_q;
  assign result_valid_o = result_valid_q;

endmodule

[hdl/stable_priority_queue_top.sv]
// top level of the stable priority queue
// a transaction's request is registered on acceptance, its compare flags in the scan state and its result in apply
// no new transaction is taken while busy; each runs load, parallel compare, then insert or shift
// result_valid_o strobes for one cycle; the receiver cannot stall it
// reset: rst_ni low clears the fill count, priority_mode and the controller
// entry cells are not cleared; only held entries are ever shown
module stable_priority_queue_top #(
  parameter int unsigned DEPTH = spq_pkg::DepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  spq_pkg::spq_cmd_t    cmd_i,
  output spq_pkg::spq_result_t result_o,
  output logic                 result_valid_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i
);
  import spq_pkg::*;

  spq_ctrl_t ctrl;

  // config is always taken
  assign cfg_ready_o = 1'b1;

  spq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .cmd_i          (cmd_i),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

[hdl/spq_checker.sv]
// port-level checker for the stable priority queue and its bind
module spq_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input spq_pkg::spq_result_t result_o,
  input logic                 result_valid_o
);
  import spq_pkg::*;

  // accepted transaction makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // result comes a fixed time after accept
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##3 result_valid_o)
    else $error("result strobe missing");

  // empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.is_empty == (result_o.entry_count == '0)))
    else $error("is_empty and entry_count disagree");

  // removed entry only on a good dequeue, head zero when empty
  a_out_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.out_valid |->
      result_o.status == ST_OK && !(result_o.is_empty && result_o.head_data != '0))
    else $error("out_valid with bad status or nonzero empty head");

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_o       (result_o),
  .result_valid_o (result_valid_o)
);

[sim/spq_tb_pkg.sv]
// result checker and order predictor for the stable priority queue testbench
`timescale 1ns / 1ps
package spq_tb_pkg;
  import spq_pkg::*;

  class queue_result_checker;
    // predicted queue contents, front at index 0
    logic [DataW-1:0] held_data [DepthDefault];
    logic [PrioW-1:0] held_prio [DepthDefault];
    int unsigned      held_count;
    logic             prio_mode;
    spq_result_t      expected_results [$];
    int unsigned      failures;

    function new();
      held_count = 0;
      prio_mode  = 1'b0;
      failures   = 0;
    endfunction

    function void set_priority_mode(logic m);
      prio_mode = m;
    endfunction

    function int unsigned waiting();
      return expected_results.size();
    endfunction

    // apply one accepted request transaction and queue its result
    function void note_request(spq_cmd_t c);
      spq_result_t r;
      int unsigned slot;
      bit          found;
      r = '0;
      r.status = ST_OK;
      if (c.action == ACT_ENQUEUE) begin
        if (held_count >= DepthDefault) begin
          r.status = ST_FULL;
        end else begin
          // stable insert: in priority mode ahead of the first strictly lower priority, else at the back
          slot  = held_count;
          found = 1'b0;
          if (prio_mode) begin
            for (int i = 0; i < held_count; i++) begin
              if (!found && held_prio[i] < c.item_priority) begin
                slot  = i;
                found = 1'b1;
              end
            end
          end
          for (int i = held_count; i > slot; i--) begin
            held_data[i] = held_data[i-1];
            held_prio[i] = held_prio[i-1];
          end
          held_data[slot] = c.item_data;
          held_prio[slot] = c.item_priority;
          held_count++;
        end
      end else begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_data     = held_data[0];
          r.out_priority = held_prio[0];
          r.out_valid    = 1'b1;
          for (int i = 1; i < held_count; i++) begin
            held_data[i-1] = held_data[i];
            held_prio[i-1] = held_prio[i];
          end
          held_count--;
        end
      end
      // head peek after the step
      if (held_count != 0) begin
        r.head_data     = held_data[0];
        r.head_priority = held_prio[0];
      end
      r.is_empty    = (held_count == 0);
      r.entry_count = held_count[CountOutW-1:0];
      expected_results.push_back(r);
    endfunction

    function void compare(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h got %h", $time, name, want, got);
        failures++;
      end
    endfunction

    // compare one result transaction against the oldest prediction
    function void check_result(spq_result_t got);
      spq_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result expected none got %h", $time, got);
        failures++;
      end else begin
        want = expected_results.pop_front();
        compare("out_data", want.out_data, got.out_data);
        compare("out_priority", DataW'(want.out_priority), DataW'(got.out_priority));
        compare("out_valid", DataW'(want.out_valid), DataW'(got.out_valid));
        compare("head_data", want.head_data, got.head_data);
        compare("head_priority", DataW'(want.head_priority), DataW'(got.head_priority));
        compare("is_empty", DataW'(want.is_empty), DataW'(got.is_empty));
        compare("entry_count", DataW'(want.entry_count), DataW'(got.entry_count));
        compare("status", DataW'(want.status), DataW'(got.status));
      end
    endfunction
  endclass

endpackage

[sim/tb_top.sv]
// top-level testbench for the stable priority queue
`timescale 1ns / 1ps
module tb_top;
  import spq_pkg::*;
  import spq_tb_pkg::*;

  localparam int unsigned CycleLimit = 150000;
  localparam int unsigned PhaseItems = 160;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  spq_cmd_t    cmd_i       = '0;
  spq_result_t result_o;
  logic        result_valid_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i  = 1'b0;

  queue_result_checker ledger = new();
  int unsigned         cycles = 0;

  stable_priority_queue_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // 20 ns clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // watch both ports and the mode register
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) ledger.check_result(result_o);
      if (start && !busy) ledger.note_request(cmd_i);
      if (cfg_valid_i && cfg_ready_o) ledger.set_priority_mode(cfg_data_i);
    end
  end

  // run deadline
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic spq_cmd_t make_cmd(action_e act, logic [DataW-1:0] d,
                                        logic [PrioW-1:0] p);
    spq_cmd_t c;
    c.action        = act;
    c.item_data     = d;
    c.item_priority = p;
    return c;
  endfunction

  // random request; enq_pct sets the fill pressure, narrow gives many ties
  function automatic spq_cmd_t rand_cmd(int unsigned enq_pct, bit narrow);
    logic [PrioW-1:0] p;
    if (narrow) p = PrioW'($urandom_range(3, 0));
    else        p = PrioW'($urandom_range(255, 0));
    if ($urandom_range(99, 0) < enq_pct) return make_cmd(ACT_ENQUEUE, $urandom, p);
    return make_cmd(ACT_DEQUEUE, $urandom, p);
  endfunction

  // hold start until the block takes the transaction
  task automatic issue(input spq_cmd_t c);
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic pause(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // stop sending and let every predicted result arrive
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (ledger.waiting() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one random phase sent in bursts
  task automatic run_phase(input int unsigned enq_pct, input bit narrow, input bit gaps);
    int unsigned left;
    int unsigned burst;
    left = PhaseItems;
    while (left > 0) begin
      burst = $urandom_range(24, 1);
      while (burst > 0 && left > 0) begin
        issue(rand_cmd(enq_pct, narrow));
        burst--;
        left--;
      end
      if (gaps && left > 0) pause($urandom_range(10, 1));
    end
  endtask

  initial begin
    logic [7:0] mode_plan;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: fifo mode after reset, dequeue on empty, fill past full
    issue(make_cmd(ACT_DEQUEUE, 32'hffff_ffff, 8'hff));
    issue(make_cmd(ACT_ENQUEUE, 32'h0000_0000, 8'h00));
    issue(make_cmd(ACT_ENQUEUE, 32'hffff_ffff, 8'hff));
    issue(make_cmd(ACT_ENQUEUE, 32'haaaa_aaaa, 8'haa));
    issue(make_cmd(ACT_ENQUEUE, 32'h5555_5555, 8'h55));
    for (int i = 4; i < DepthDefault; i++) begin
      issue(make_cmd(ACT_ENQUEUE, $urandom, 8'(i * 17)));
    end
    issue(make_cmd(ACT_ENQUEUE, 32'h1234_5678, 8'h80));
    issue(make_cmd(ACT_DEQUEUE, 32'h0, 8'h0));
    issue(make_cmd(ACT_DEQUEUE, 32'h0, 8'h0));

    // priority mode switched on while entries are held
    settle();
    write_mode(1'b1);
    @(posedge clk_i);
    issue(make_cmd(ACT_ENQUEUE, 32'hdead_beef, 8'hff));
    issue(make_cmd(ACT_ENQUEUE, 32'h0bad_f00d, 8'h00));
    issue(make_cmd(ACT_ENQUEUE, 32'hc0de_c0de, 8'h80));
    issue(make_cmd(ACT_DEQUEUE, 32'h0, 8'h0));

    // random phases across both modes and fill pressures
    mode_plan = 8'b1101_0110;
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      write_mode(mode_plan[ph]);
      @(posedge clk_i);
      case (ph % 3)
        0: run_phase(75, ph[0], ph != 3);
        1: run_phase(50, ph[0], ph != 4);
        default: run_phase(25, ph[0], 1'b1);
      endcase
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (ledger.waiting() != 0) begin
      $display("%0t: leftover results expected 0 got %0d", $time, ledger.waiting());
      ledger.failures++;
    end
    if (ledger.failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/spq_pkg.sv
hdl/spq_ctrl.sv
hdl/spq_datapath.sv
hdl/stable_priority_queue_top.sv
hdl/spq_checker.sv
sim/spq_tb_pkg.sv
sim/tb_top.sv
